FILE: rtl/srt_pkg.sv
// Shared types, codes and digit helper for the signed radix sorter.
`timescale 1ns / 1ps
package srt_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 10;
  localparam int DIGIT_W = 8;
  localparam int TABLE_DEPTH = 256;

  localparam logic [DIGIT_W-1:0] TABLE_LAST = 8'd255;
  localparam logic [DIGIT_W-1:0] TOP_FLIP   = 8'd128;
  localparam logic [1:0]         PASS_LAST  = 2'd3;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Command strobes from the controller to the datapath.
  typedef struct packed {
    logic app_wr;   // store the appended value at the element index
    logic rd_req;   // a read request is accepted this cycle
    logic rd_ok;    // the read request is in range
    logic clr_cnt;  // zero the count table entry at the table index
    logic dig_rd;   // latch source value and digit, read its count
    logic cnt_inc;  // write back count plus one for the latched digit
    logic pre_wr;   // write running sum at the table index, add the count
    logic scatter;  // write the latched value at its slot in the target store
  } srt_cmd_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [VALUE_W-1:0] v,
                                                  input logic [1:0] pass);
    logic [DIGIT_W-1:0] d;
    case (pass)
      2'd0: d = v[7:0];
      2'd1: d = v[15:8];
      2'd2: d = v[23:16];
      default: d = v[31:24] ^ TOP_FLIP;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/srt_if.sv
// Request and response channel interfaces of the radix sorter.
`timescale 1ns / 1ps
interface srt_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value;
  logic               last;
  logic [9:0]         position;

  modport source (output valid, op, value, last, position, input ready);
  modport sink (input valid, op, value, last, position, output ready);
endinterface

interface srt_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               in_range;

  modport source (output valid, sorted_value, in_range, input ready);
  modport sink (input valid, sorted_value, in_range, output ready);
endinterface

FILE: rtl/srt_ctrl.sv
// Controller: request acceptance, element count and the four-pass sort sequencer.
`timescale 1ns / 1ps
module srt_ctrl import srt_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  input  logic                               req_op,
  input  logic                               req_last,
  input  logic [POS_W-1:0]                   req_position,
  input  logic                               cred_ok,
  output logic                               req_ready,
  output srt_cmd_t                           cmd,
  output logic [1:0]                         pass,
  output logic [DIGIT_W-1:0]                 tix,
  output logic [$clog2(MAX_ELEMENTS)-1:0]    idx
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_CNT_RD  = 4'd2;
  localparam logic [3:0] S_CNT_DIG = 4'd3;
  localparam logic [3:0] S_CNT_WR  = 4'd4;
  localparam logic [3:0] S_PRE_RD  = 4'd5;
  localparam logic [3:0] S_PRE_WR  = 4'd6;
  localparam logic [3:0] S_SC_RD   = 4'd7;
  localparam logic [3:0] S_SC_DIG  = 4'd8;
  localparam logic [3:0] S_SC_WR   = 4'd9;

  logic [3:0]         state, state_next;
  logic [CW-1:0]      element_count, element_count_next;
  logic               sort_done, sort_done_next;
  logic [1:0]         pass_next;
  logic [DIGIT_W-1:0] tix_next;
  logic [AW-1:0]      eix, eix_next;
  logic [CW-1:0]      base;
  logic               room;
  logic               last_elem;
  logic               accept;

  assign req_ready = (state == S_IDLE) && cred_ok;
  assign accept    = req_valid && req_ready;
  // a finished set restarts from zero on the next append
  assign base      = sort_done ? '0 : element_count;
  assign room      = base < CW'(MAX_ELEMENTS);
  assign last_elem = (CW'(eix) + CW'(1)) == element_count;
  assign idx       = (state == S_IDLE) ? base[AW-1:0] : eix;

  always_comb begin
    state_next         = state;
    element_count_next = element_count;
    sort_done_next     = sort_done;
    pass_next          = pass;
    tix_next           = tix;
    eix_next           = eix;
    cmd                = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_op == OP_APPEND) begin
            sort_done_next     = 1'b0;
            element_count_next = base;
            if (room) begin
              cmd.app_wr         = 1'b1;
              element_count_next = base + CW'(1);
            end
            if (req_last) begin
              state_next = S_CLEAR;
              pass_next  = '0;
              tix_next   = '0;
              eix_next   = '0;
            end
          end else begin
            cmd.rd_req = 1'b1;
            cmd.rd_ok  = sort_done && (XW'(req_position) < XW'(element_count));
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_cnt = 1'b1;
        tix_next    = tix + DIGIT_W'(1);
        if (tix == TABLE_LAST) begin
          state_next = S_CNT_RD;
          eix_next   = '0;
        end
      end
      S_CNT_RD: state_next = S_CNT_DIG;
      S_CNT_DIG: begin
        cmd.dig_rd = 1'b1;
        state_next = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd.cnt_inc = 1'b1;
        if (last_elem) begin
          eix_next   = '0;
          tix_next   = '0;
          state_next = S_PRE_RD;
        end else begin
          eix_next   = eix + AW'(1);
          state_next = S_CNT_RD;
        end
      end
      S_PRE_RD: state_next = S_PRE_WR;
      S_PRE_WR: begin
        cmd.pre_wr = 1'b1;
        tix_next   = tix + DIGIT_W'(1);
        state_next = (tix == TABLE_LAST) ? S_SC_RD : S_PRE_RD;
      end
      S_SC_RD: state_next = S_SC_DIG;
      S_SC_DIG: begin
        cmd.dig_rd = 1'b1;
        state_next = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.cnt_inc = 1'b1;
        cmd.scatter = 1'b1;
        if (last_elem) begin
          eix_next = '0;
          tix_next = '0;
          if (pass == PASS_LAST) begin
            sort_done_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            pass_next  = pass + 2'd1;
            state_next = S_CLEAR;
          end
        end else begin
          eix_next   = eix + AW'(1);
          state_next = S_SC_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      element_count <= '0;
      sort_done     <= 1'b0;
      pass          <= '0;
      tix           <= '0;
      eix           <= '0;
    end else begin
      state         <= state_next;
      element_count <= element_count_next;
      sort_done     <= sort_done_next;
      pass          <= pass_next;
      tix           <= tix_next;
      eix           <= eix_next;
    end
  end

endmodule

FILE: rtl/srt_datapath.sv
// Datapath: data, scratch and count memories, running sum and response queue.
`timescale 1ns / 1ps
module srt_datapath import srt_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  srt_cmd_t                        cmd,
  input  logic [1:0]                      pass,
  input  logic [DIGIT_W-1:0]              tix,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] idx,
  input  logic [VALUE_W-1:0]              req_value,
  input  logic [POS_W-1:0]                req_position,
  input  logic                            rsp_ready,
  output logic                            cred_ok,
  output logic                            rsp_valid,
  output logic [VALUE_W-1:0]              rsp_value,
  output logic                            rsp_in_range
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = (AW > POS_W) ? AW : POS_W;

  logic [VALUE_W-1:0] data_mem    [MAX_ELEMENTS];
  logic [VALUE_W-1:0] scratch_mem [MAX_ELEMENTS];
  logic [CW-1:0]      cnt_mem     [TABLE_DEPTH];

  logic [VALUE_W-1:0] data_q, scratch_q, src_q, val_reg;
  logic [CW-1:0]      cnt_q, running;
  logic [DIGIT_W-1:0] dig_reg;
  logic [PW-1:0]      pos_w;
  logic [AW-1:0]      data_raddr, data_waddr, slot;
  logic [VALUE_W-1:0] data_wdata;
  logic               data_we, scratch_we, cnt_we;
  logic [DIGIT_W-1:0] cnt_raddr, cnt_waddr;
  logic [CW-1:0]      cnt_wdata;

  logic               pend, pend_ok;
  logic [1:0]         q_cnt;
  logic [VALUE_W-1:0] q0_value, q1_value, new_value;
  logic               q0_ok, q1_ok;
  logic               enq, deq;

  assign pos_w      = PW'(req_position);
  assign src_q      = pass[0] ? scratch_q : data_q;
  assign slot       = cnt_q[AW-1:0];
  assign data_raddr = cmd.rd_req ? pos_w[AW-1:0] : idx;

  // even passes move data to scratch, odd passes move scratch back to data
  assign data_we    = cmd.app_wr || (cmd.scatter && pass[0]);
  assign data_waddr = cmd.app_wr ? idx : slot;
  assign data_wdata = cmd.app_wr ? req_value : val_reg;
  assign scratch_we = cmd.scatter && !pass[0];

  assign cnt_raddr = cmd.dig_rd ? digit_of(src_q, pass) : tix;
  assign cnt_we    = cmd.clr_cnt || cmd.pre_wr || cmd.cnt_inc;
  assign cnt_waddr = cmd.cnt_inc ? dig_reg : tix;
  always_comb begin
    if (cmd.cnt_inc) begin
      cnt_wdata = cnt_q + CW'(1);
    end else if (cmd.pre_wr) begin
      cnt_wdata = running;
    end else begin
      cnt_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_q <= data_mem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (scratch_we) begin
      scratch_mem[slot] <= val_reg;
    end
    scratch_q <= scratch_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.dig_rd) begin
      dig_reg <= digit_of(src_q, pass);
      val_reg <= src_q;
    end
    if (cmd.clr_cnt) begin
      running <= '0;
    end else if (cmd.pre_wr) begin
      running <= running + cnt_q;
    end
  end

  // Two-entry response queue, fed in the cycle after the read request.
  assign enq       = pend;
  assign new_value = pend_ok ? data_q : '0;
  assign rsp_valid = (q_cnt != 2'd0);
  assign deq       = rsp_valid && rsp_ready;
  assign cred_ok   = ((3'(q_cnt) + 3'(pend)) < 3'd2) || deq;
  assign rsp_value    = q0_value;
  assign rsp_in_range = q0_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      pend_ok <= 1'b0;
      q_cnt   <= '0;
    end else begin
      pend    <= cmd.rd_req;
      pend_ok <= cmd.rd_ok;
      q_cnt   <= q_cnt + 2'(enq) - 2'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq && deq) begin
      if (q_cnt == 2'd1) begin
        q0_value <= new_value;
        q0_ok    <= pend_ok;
      end else begin
        q0_value <= q1_value;
        q0_ok    <= q1_ok;
        q1_value <= new_value;
        q1_ok    <= pend_ok;
      end
    end else if (enq) begin
      if (q_cnt == 2'd0) begin
        q0_value <= new_value;
        q0_ok    <= pend_ok;
      end else begin
        q1_value <= new_value;
        q1_ok    <= pend_ok;
      end
    end else if (deq) begin
      q0_value <= q1_value;
      q0_ok    <= q1_ok;
    end
  end

endmodule

FILE: rtl/signed_int_radix_sorter_unit.sv
// Signed 32-bit radix sorter top level: channels, controller and datapath.
// Appends (op 0) and reads (op 1) are accepted while the sorter is idle; a
// read answers with its element through a two-entry response queue once its
// data-memory read and pending flag are registered, so reads stream at one
// per cycle while the response side keeps up. An append with last set
// starts a four-pass LSD radix sort over the N stored elements (signed
// ascending, stable); requests stall during it. Each pass zeroes the count
// table, counts digits, forms prefix sums and scatters: every element step
// is a source read, a count-table read and a write-back on the count
// memory, which has one read and one write port. Appends beyond
// MAX_ELEMENTS are dropped; an append after a finished sort starts a new set.
`timescale 1ns / 1ps
module signed_int_radix_sorter_unit import srt_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  srt_req_if.sink          req,
  srt_rsp_if.source        rsp
);

  localparam int AW = $clog2(MAX_ELEMENTS);

  srt_cmd_t           cmd;
  logic [1:0]         pass;
  logic [DIGIT_W-1:0] tix;
  logic [AW-1:0]      idx;
  logic               cred_ok;
  logic [VALUE_W-1:0] rsp_value;

  srt_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_op       (req.op),
    .req_last     (req.last),
    .req_position (req.position),
    .cred_ok      (cred_ok),
    .req_ready    (req.ready),
    .cmd          (cmd),
    .pass         (pass),
    .tix          (tix),
    .idx          (idx)
  );

  srt_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pass         (pass),
    .tix          (tix),
    .idx          (idx),
    .req_value    (req.value),
    .req_position (req.position),
    .rsp_ready    (rsp.ready),
    .cred_ok      (cred_ok),
    .rsp_valid    (rsp.valid),
    .rsp_value    (rsp_value),
    .rsp_in_range (rsp.in_range)
  );

  assign rsp.sorted_value = rsp_value;

endmodule

FILE: rtl/srt_checker.sv
// Port-level checks for the radix sorter, bound to the top level.
`timescale 1ns / 1ps
module srt_checker import srt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               req_op,
  input logic               req_last,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [VALUE_W-1:0] rsp_sorted_value,
  input logic               rsp_in_range
);

  // reset empties the response queue
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_in_range))
    else $error("stalled response changed");

  // an out-of-range answer carries zero
  a_zero_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_in_range |-> rsp_sorted_value == '0)
    else $error("out-of-range response with nonzero value");

  // the final append starts the sort, which blocks further requests
  a_sort_stall: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_op == OP_APPEND && req_last |=> !req_ready)
    else $error("request accepted right after last append");

endmodule

bind signed_int_radix_sorter_unit srt_checker u_srt_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_op           (req.op),
  .req_last         (req.last),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_sorted_value (rsp.sorted_value),
  .rsp_in_range     (rsp.in_range)
);

FILE: sim/srt_checker.sv
// Passive checker: predicts sorted lookups from accepted requests and compares responses.
`timescale 1ns / 1ps
module srt_scoreboard import srt_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic clk,
  input  logic rst,
  srt_req_if   req,
  srt_rsp_if   rsp,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               hit;
  } answer_t;

  logic [VALUE_W-1:0] loaded [MAX_ELEMENTS];
  logic [VALUE_W-1:0] shadow [MAX_ELEMENTS];
  int unsigned        fill;
  bit                 ordered;
  answer_t            answers_due [$];

  // One stable counting pass on an 8-bit digit, between the two stores.
  function automatic void digit_pass(input int shift, input logic [DIGIT_W-1:0] flip,
                                     input bit into_shadow);
    int unsigned        bucket [TABLE_DEPTH];
    int unsigned        running;
    int unsigned        c;
    logic [VALUE_W-1:0] v;
    logic [DIGIT_W-1:0] d;
    for (int i = 0; i < TABLE_DEPTH; i++) bucket[i] = 0;
    for (int unsigned i = 0; i < fill; i++) begin
      v = into_shadow ? loaded[i] : shadow[i];
      d = v[shift +: DIGIT_W] ^ flip;
      bucket[d]++;
    end
    running = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      c = bucket[i];
      bucket[i] = running;
      running += c;
    end
    for (int unsigned i = 0; i < fill; i++) begin
      v = into_shadow ? loaded[i] : shadow[i];
      d = v[shift +: DIGIT_W] ^ flip;
      if (into_shadow) shadow[bucket[d]] = v;
      else loaded[bucket[d]] = v;
      bucket[d]++;
    end
  endfunction

  function automatic void sort_loaded();
    digit_pass(0, '0, 1'b1);
    digit_pass(8, '0, 1'b0);
    digit_pass(16, '0, 1'b1);
    // flip the sign bit of the top digit for signed order
    digit_pass(24, TOP_FLIP, 1'b0);
    ordered = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    answer_t due;
    answer_t got;
    if (rst) begin
      fill = 0;
      ordered = 1'b0;
      errors = 0;
      answers_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.value = rsp.sorted_value;
        got.hit   = rsp.in_range;
        if (answers_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: response with no request pending: value %h in_range %b",
                     $realtime, got.value, got.hit);
          errors++;
        end else begin
          due = answers_due.pop_front();
          if (got.value !== due.value || got.hit !== due.hit) begin
            if (errors < 10)
              $display("%0t: lookup mismatch: expected value %h in_range %b, got %h %b",
                       $realtime, due.value, due.hit, got.value, got.hit);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_APPEND) begin
          if (ordered) begin
            fill = 0;
            ordered = 1'b0;
          end
          // drop appends once the store is full
          if (fill < MAX_ELEMENTS) begin
            loaded[fill] = req.value;
            fill++;
          end
          if (req.last) sort_loaded();
        end else begin
          if (ordered && req.position < fill) begin
            due.value = loaded[req.position];
            due.hit   = 1'b1;
          end else begin
            due.value = '0;
            due.hit   = 1'b0;
          end
          answers_due.push_back(due);
        end
      end
    end
    outstanding <= answers_due.size();
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the signed radix sorter: stimulus, response pacing and verdict.
`timescale 1ns / 1ps
module tb;
  import srt_pkg::*;

  localparam int CAPACITY     = 1024;
  localparam int RANDOM_ITEMS = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 40;
  // a full 1024-element sort stalls requests, but for less than this limit
  localparam int QUIET_LIMIT  = 150000;

  logic clk;
  logic rst;

  srt_req_if req ();
  srt_rsp_if rsp ();

  int errors;
  int outstanding;
  int quiet_cycles;
  int sent;
  int hold_asks;
  bit steady;
  bit calm;
  int unsigned stocked;
  bit settled;

  signed_int_radix_sorter_unit #(.MAX_ELEMENTS(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  srt_scoreboard #(.MAX_ELEMENTS(CAPACITY)) u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Response side: random stall bursts, plus long hold-offs on request.
  initial begin : drain_side
    int holds_done;
    holds_done = 0;
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic issue(input logic op, input logic [VALUE_W-1:0] value, input logic last,
                       input logic [POS_W-1:0] position);
    req.valid    <= 1'b1;
    req.op       <= op;
    req.value    <= value;
    req.last     <= last;
    req.position <= position;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic append(input logic [VALUE_W-1:0] value, input logic last);
    if (settled) begin
      stocked = 0;
      settled = 1'b0;
    end
    if (stocked < CAPACITY) stocked++;
    if (last) settled = 1'b1;
    issue(OP_APPEND, value, last, POS_W'($urandom));
  endtask

  task automatic lookup(input logic [POS_W-1:0] position);
    issue(OP_READ, $urandom, 1'($urandom), position);
  endtask

  task automatic maybe_idle();
    if (!steady && !calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Hold off new requests until every lookup has been answered.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      // narrow range around zero gives many ties
      1: return VALUE_W'($signed($urandom_range(0, 7)) - 4);
      2: return {8'($urandom), 24'h0};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (settled && stocked > 0 && $urandom_range(0, 3) != 0)
      return POS_W'($urandom_range(0, stocked - 1));
    return POS_W'($urandom_range(0, CAPACITY - 1));
  endfunction

  initial begin : stimulus
    int unsigned set_len;
    int unsigned reads;
    int          sets;
    int          big_at;
    int          hold_at;
    int          pause_at;
    bit          close;
    logic [VALUE_W-1:0] corners [8];

    corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h0000_0080, 32'hFF00_0000, 32'h8000_0000};
    sent = 0;
    hold_asks = 0;
    steady = 1'b0;
    calm = 1'b0;
    stocked = 0;
    settled = 1'b0;
    req.valid    <= 1'b0;
    req.op       <= OP_APPEND;
    req.value    <= '0;
    req.last     <= 1'b0;
    req.position <= '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // lookups before any sort answer out of range
    lookup('0);
    issue(OP_READ, 32'hFFFF_FFFF, 1'b1, POS_W'(CAPACITY - 1));
    for (int i = 0; i < 8; i++) begin
      maybe_idle();
      append(corners[i], i == 7);
    end
    for (int i = 0; i < 9; i++) begin
      maybe_idle();
      lookup(POS_W'(i));
    end
    lookup(POS_W'(CAPACITY - 1));
    // append after a finished sort starts a fresh set
    append(32'h0000_0005, 1'b1);
    lookup('0);
    lookup(POS_W'(1));
    drain();

    big_at   = $urandom_range(2, 6);
    hold_at  = 4;
    pause_at = 7;
    sets = 0;
    while (sent < RANDOM_ITEMS) begin
      calm   = sent > (RANDOM_ITEMS * 4) / 5;
      steady = $urandom_range(0, 3) == 0;
      if (sets == big_at) set_len = CAPACITY + $urandom_range(1, 6);
      else if ($urandom_range(0, 9) == 0) set_len = $urandom_range(17, 120);
      else set_len = $urandom_range(1, 16);
      // now and then leave a set open so the next one piles onto it
      close = sets == hold_at || sets == big_at || $urandom_range(0, 9) != 0;
      for (int unsigned k = 0; k < set_len; k++) begin
        maybe_idle();
        if ($urandom_range(0, 19) == 0) lookup(POS_W'($urandom));
        append(pick_value(), close && k == set_len - 1);
      end
      reads = $urandom_range(1, 24);
      if (sets == hold_at) begin
        // stall the response side while requests keep coming
        hold_asks <= hold_asks + 1;
        steady = 1'b1;
        reads = 24;
      end
      for (int unsigned k = 0; k < reads; k++) begin
        maybe_idle();
        lookup(pick_position());
      end
      if (sets == pause_at || $urandom_range(0, 7) == 0) drain();
      sets++;
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
